// File: rtl/gbd_pkg.sv
// Shared widths, register indexes, reset values and item types for the breadcrumb decimator.
package gbd_pkg;

  localparam int TIME_W  = 32;
  localparam int LAT_W   = 31;
  localparam int LON_W   = 32;
  localparam int ALT_W   = 25;
  localparam int SLOT_W  = 6;
  localparam int CNT_W   = 7;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DISTANCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_INTERVAL = 2'd2;

  localparam logic [CFG_W-1:0] MIN_INTERVAL_RST = 16'd500;
  localparam logic [CFG_W-1:0] MIN_DISTANCE_RST = 16'd30;
  localparam logic [CFG_W-1:0] MAX_INTERVAL_RST = 16'd3000;

  localparam logic KIND_FIX   = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  typedef struct packed {
    logic                    kind;
    logic [TIME_W-1:0]       now_ms;
    logic                    fix_valid;
    logic signed [LAT_W-1:0] lat_e7;
    logic signed [LON_W-1:0] lon_e7;
    logic signed [ALT_W-1:0] alt_cm;
  } fix_t;

  typedef struct packed {
    logic [TIME_W-1:0]       last_time;
    logic signed [LAT_W-1:0] last_lat;
    logic signed [LON_W-1:0] last_lon;
  } trail_t;

  typedef struct packed {
    logic [CFG_W-1:0] min_interval_ms;
    logic [CFG_W-1:0] min_distance;
    logic [CFG_W-1:0] max_interval_ms;
  } cfg_t;

endpackage

// File: rtl/gbd_if.sv
// Valid/ready channel interfaces for fix items and trail point items.
interface gbd_fix_if;
  import gbd_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic [TIME_W-1:0]       now_ms;
  logic                    fix_valid;
  logic signed [LAT_W-1:0] lat_e7;
  logic signed [LON_W-1:0] lon_e7;
  logic signed [ALT_W-1:0] alt_cm;

  modport source (
    output valid, kind, now_ms, fix_valid, lat_e7, lon_e7, alt_cm,
    input  ready
  );
  modport sink (
    input  valid, kind, now_ms, fix_valid, lat_e7, lon_e7, alt_cm,
    output ready
  );
endinterface

interface gbd_point_if;
  import gbd_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    recorded;
  logic [SLOT_W-1:0]       slot;
  logic signed [LAT_W-1:0] point_lat;
  logic signed [LON_W-1:0] point_lon;
  logic signed [ALT_W-1:0] point_alt;
  logic [TIME_W-1:0]       point_time;
  logic [CNT_W-1:0]        stored_count;
  logic                    home_set;
  logic signed [LAT_W-1:0] home_lat;
  logic signed [LON_W-1:0] home_lon;

  modport source (
    output valid, recorded, slot, point_lat, point_lon, point_alt, point_time,
           stored_count, home_set, home_lat, home_lon,
    input  ready
  );
  modport sink (
    input  valid, recorded, slot, point_lat, point_lon, point_alt, point_time,
           stored_count, home_set, home_lat, home_lon,
    output ready
  );
endinterface

// File: rtl/gbd_decide.sv
// Log decision: time gates and Manhattan distance against the last trail point.
module gbd_decide (
  input  gbd_pkg::fix_t   fix,
  input  gbd_pkg::trail_t trail,
  input  gbd_pkg::cfg_t   cfg,
  output logic            record
);
  import gbd_pkg::*;

  logic [31:0] lat_now, lat_last, dlat, dlon, alat, alon, span, dt;
  logic        time_ok, far_ok, stale;

  always_comb begin
    lat_now  = {fix.lat_e7[LAT_W-1], fix.lat_e7};
    lat_last = {trail.last_lat[LAT_W-1], trail.last_lat};
    dlat     = lat_now - lat_last;
    dlon     = fix.lon_e7 - trail.last_lon;
    alat     = dlat[31] ? (32'd0 - dlat) : dlat;
    alon     = dlon[31] ? (32'd0 - dlon) : dlon;
    span     = alat + alon;
    dt       = fix.now_ms - trail.last_time;
    time_ok  = dt >= {16'd0, cfg.min_interval_ms};
    far_ok   = span >= {16'd0, cfg.min_distance};
    stale    = dt >= {16'd0, cfg.max_interval_ms};
    record   = (fix.kind == KIND_FIX) && fix.fix_valid && time_ok && (far_ok || stale);
  end

endmodule

// File: rtl/gps_breadcrumb_decimator.sv
// Breadcrumb decimator top level: input register, log decision, trail state, result register.
//
//   channel  dir  handshake     content
//   fix_ch   in   valid/ready   kind, now_ms, fix_valid, lat_e7, lon_e7, alt_cm
//   pt_ch    out  valid/ready   recorded, slot, point fields, count, home
//   cfg      in   cfg_we        cfg_index, cfg_data (three 16-bit registers)
//
// One item per cycle sustained while pt_ch.ready holds.
// The decision and trail update sit between the input register and the result register.
// Synchronous reset clears the trail and restores the register defaults.
// A stalled result holds; the input register keeps accepting while it can drain.
module gps_breadcrumb_decimator #(
  parameter int POINT_COUNT = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [gbd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gbd_pkg::CFG_W-1:0]        cfg_data,
  gbd_fix_if.sink                          fix_ch,
  gbd_point_if.source                      pt_ch
);
  import gbd_pkg::*;

  localparam int HW = (POINT_COUNT > 1) ? $clog2(POINT_COUNT) : 1;
  localparam int CW = $clog2(POINT_COUNT + 1);

  cfg_t   cfg;
  fix_t   s1;
  logic   s1_valid;
  logic   s1_move;
  logic   out_valid;
  logic   record;

  trail_t                  trail, trail_next;
  logic [HW-1:0]           head, head_next;
  logic [CW-1:0]           count, count_next;
  logic                    home_locked, home_locked_next;
  logic signed [LAT_W-1:0] home_lat, home_lat_next;
  logic signed [LON_W-1:0] home_lon, home_lon_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_interval_ms <= MIN_INTERVAL_RST;
      cfg.min_distance    <= MIN_DISTANCE_RST;
      cfg.max_interval_ms <= MAX_INTERVAL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_INTERVAL: cfg.min_interval_ms <= cfg_data;
        REG_MIN_DISTANCE: cfg.min_distance    <= cfg_data;
        REG_MAX_INTERVAL: cfg.max_interval_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s1_move      = s1_valid && (!out_valid || pt_ch.ready);
  assign fix_ch.ready = !s1_valid || s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (fix_ch.ready) begin
      s1_valid <= fix_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fix_ch.valid && fix_ch.ready) begin
      s1.kind      <= fix_ch.kind;
      s1.now_ms    <= fix_ch.now_ms;
      s1.fix_valid <= fix_ch.fix_valid;
      s1.lat_e7    <= fix_ch.lat_e7;
      s1.lon_e7    <= fix_ch.lon_e7;
      s1.alt_cm    <= fix_ch.alt_cm;
    end
  end

  gbd_decide u_decide (
    .fix    (s1),
    .trail  (trail),
    .cfg    (cfg),
    .record (record)
  );

  always_comb begin
    trail_next       = trail;
    head_next        = head;
    count_next       = count;
    home_locked_next = home_locked;
    home_lat_next    = home_lat;
    home_lon_next    = home_lon;
    if (s1.kind == KIND_CLEAR) begin
      trail_next       = '0;
      head_next        = '0;
      count_next       = '0;
      home_locked_next = 1'b0;
      home_lat_next    = '0;
      home_lon_next    = '0;
    end else if (record) begin
      trail_next.last_time = s1.now_ms;
      trail_next.last_lat  = s1.lat_e7;
      trail_next.last_lon  = s1.lon_e7;
      head_next  = (head == HW'(POINT_COUNT - 1)) ? '0 : head + 1'b1;
      if (count < CW'(POINT_COUNT)) begin
        count_next = count + 1'b1;
      end
      if (!home_locked) begin
        home_locked_next = 1'b1;
        home_lat_next    = s1.lat_e7;
        home_lon_next    = s1.lon_e7;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trail       <= '0;
      head        <= '0;
      count       <= '0;
      home_locked <= 1'b0;
      home_lat    <= '0;
      home_lon    <= '0;
    end else if (s1_move) begin
      trail       <= trail_next;
      head        <= head_next;
      count       <= count_next;
      home_locked <= home_locked_next;
      home_lat    <= home_lat_next;
      home_lon    <= home_lon_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (pt_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      pt_ch.recorded     <= record;
      pt_ch.slot         <= record ? SLOT_W'(head) : '0;
      pt_ch.point_lat    <= record ? s1.lat_e7 : '0;
      pt_ch.point_lon    <= record ? s1.lon_e7 : '0;
      pt_ch.point_alt    <= record ? s1.alt_cm : '0;
      pt_ch.point_time   <= record ? s1.now_ms : '0;
      pt_ch.stored_count <= CNT_W'(count_next);
      pt_ch.home_set     <= home_locked_next;
      pt_ch.home_lat     <= home_lat_next;
      pt_ch.home_lon     <= home_lon_next;
    end
  end

  assign pt_ch.valid = out_valid;

endmodule
